// ===== rtl/core/ilss_pkg.sv =====
// Shared constants, command and status codes, and the cell command struct.
package ilss_pkg;

	localparam int CAPACITY = 64;

	localparam int CMD_W  = 3;
	localparam int POS_W  = 6;
	localparam int WORD_W = 32;
	localparam int LEN_W  = 7;
	localparam int STAT_W = 2;

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int LWID_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	localparam int GRP    = 8;
	localparam int NGRP   = (CAPACITY + GRP - 1) / GRP;

	localparam int IN_W   = 48;
	localparam int OUT_W  = 48;

	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic             go;
		logic             ok;
		logic [CMD_W-1:0] op;
		logic [CMP_W-1:0] pos;
		logic [CMP_W-1:0] cnt;
	} cell_cmd_t;

endpackage

// ===== rtl/core/ilss_cell.sv =====
// One list entry: holds a word, shifts with its neighbors, drives a read tap.
module ilss_cell (
	input  logic                        clk,
	input  ilss_pkg::cell_cmd_t         cmd,
	input  logic [ilss_pkg::CMP_W-1:0]  idx,
	input  logic [ilss_pkg::WORD_W-1:0] word_in,
	input  logic [ilss_pkg::WORD_W-1:0] left,
	input  logic [ilss_pkg::WORD_W-1:0] right,
	output logic [ilss_pkg::WORD_W-1:0] data,
	output logic [ilss_pkg::WORD_W-1:0] tap
);
	import ilss_pkg::*;

	logic [WORD_W-1:0] data_q;
	logic [WORD_W-1:0] tap_q;
	logic [WORD_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		if (cmd.go && cmd.ok) begin
			case (cmd.op)
				CMD_APPEND: begin
					if (idx == cmd.cnt) data_d = word_in;
				end
				CMD_SET: begin
					if (idx == cmd.pos) data_d = word_in;
				end
				CMD_INSERT: begin
					if (idx == cmd.pos) data_d = word_in;
					else if (idx > cmd.pos) data_d = left;
				end
				CMD_DELETE: begin
					if (idx >= cmd.pos) data_d = right;
				end
				default: data_d = data_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
		if (cmd.go) begin
			tap_q <= (cmd.ok && cmd.op == CMD_GET && idx == cmd.pos) ? data_q : '0;
		end
	end

	assign data = data_q;
	assign tap  = tap_q;

endmodule

// ===== rtl/core/indexed_list_shift_store_top.sv =====
// Top level: bounded ordered word list built from a chain of shifting cells.
//
//  channel | dir | handshake          | payload
//  s       | in  | s_tvalid/s_tready  | s_tdata: command, position, word_in
//  m       | out | m_tvalid/m_tready  | m_tdata: word_out, length, status
//
// Every cell updates in the cycle a request is taken, so one request per cycle
// while m does not stall. A result passes cell read tap, group OR stage, output
// register. Reset clears the count and the pipeline valids; entries are
// left as they are. A stall on m backs up through the stages and drops s_tready.
module indexed_list_shift_store_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // command[2:0], position[8:3], word_in[40:9], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // word_out[31:0], length[38:32], status[40:39], zero pad
);
	import ilss_pkg::*;

	logic [CMD_W-1:0]  in_cmd;
	logic [POS_W-1:0]  in_pos;
	logic [WORD_W-1:0] in_word;
	logic [CMP_W-1:0]  pos_x;
	logic [CMP_W-1:0]  cnt_x;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic              in_range;
	logic              full;
	logic              ok;
	logic [STAT_W-1:0] stat_d;
	logic [LWID_W-1:0] len_wide;
	logic              accept;

	cell_cmd_t         cmd;

	logic              valid_s1;
	logic [LEN_W-1:0]  len_s1;
	logic [STAT_W-1:0] stat_s1;
	logic              valid_s2;
	logic [LEN_W-1:0]  len_s2;
	logic [STAT_W-1:0] stat_s2;
	logic [WORD_W-1:0] grp_s2 [NGRP];
	logic [WORD_W-1:0] grp_d  [NGRP];
	logic [WORD_W-1:0] rd_d;

	logic              m_valid_q;
	logic [WORD_W-1:0] m_word_q;
	logic [LEN_W-1:0]  m_len_q;
	logic [STAT_W-1:0] m_stat_q;

	logic              out_free;
	logic              s2_move;
	logic              s2_free;
	logic              s1_move;

	logic [WORD_W-1:0] cell_data [CAPACITY];
	logic [WORD_W-1:0] cell_tap  [CAPACITY];

	assign in_cmd  = s_tdata[2:0];
	assign in_pos  = s_tdata[8:3];
	assign in_word = s_tdata[40:9];

	assign pos_x    = CMP_W'(in_pos);
	assign cnt_x    = CMP_W'(count_q);
	assign in_range = pos_x < cnt_x;
	assign full     = count_q == CNT_W'(CAPACITY);

	always_comb begin
		ok      = 1'b0;
		stat_d  = ST_OK;
		count_d = count_q;
		case (in_cmd)
			CMD_APPEND: begin
				if (full) stat_d = ST_FULL;
				else begin
					ok      = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			CMD_SET, CMD_GET: begin
				if (!in_range) stat_d = ST_RANGE;
				else ok = 1'b1;
			end
			CMD_INSERT: begin
				if (!in_range) stat_d = ST_RANGE;
				else if (full) stat_d = ST_FULL;
				else begin
					ok      = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			CMD_DELETE: begin
				if (!in_range) stat_d = ST_RANGE;
				else begin
					ok      = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			default: ok = 1'b0;
		endcase
	end

	assign len_wide = LWID_W'(count_d);

	assign out_free = !m_valid_q || m_tready;
	assign s2_move  = valid_s2 && out_free;
	assign s2_free  = !valid_s2 || s2_move;
	assign s1_move  = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s1_move;
	assign accept   = s_tvalid && s_tready;

	assign cmd.go  = accept;
	assign cmd.ok  = ok;
	assign cmd.op  = in_cmd;
	assign cmd.pos = pos_x;
	assign cmd.cnt = cnt_x;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = in_word;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		ilss_cell u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.idx     (CMP_W'(i)),
			.word_in (in_word),
			.left    (left_w),
			.right   (right_w),
			.data    (cell_data[i]),
			.tap     (cell_tap[i])
		);
	end

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < CAPACITY) grp_d[g] = grp_d[g] | cell_tap[g * GRP + k];
			end
		end
	end

	always_comb begin
		rd_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			rd_d = rd_d | grp_s2[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) count_q <= count_d;
			if (s_tready) valid_s1 <= s_tvalid;
			if (s2_free) valid_s2 <= valid_s1;
			if (out_free) m_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			len_s1  <= len_wide[LEN_W-1:0];
			stat_s1 <= stat_d;
		end
		if (s1_move) begin
			len_s2  <= len_s1;
			stat_s2 <= stat_s1;
			grp_s2  <= grp_d;
		end
		if (s2_move) begin
			m_word_q <= rd_d;
			m_len_q  <= len_s2;
			m_stat_q <= stat_s2;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, m_stat_q, m_len_q, m_word_q};

endmodule

// ===== rtl/core/ilss_checker.sv =====
// Port-level checks on the list store's result stream, bound to the top level.
module ilss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);
	import ilss_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[40:39] <= ST_FULL)
		else $error("bad status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[40:39] != ST_OK |-> m_tdata[31:0] == 32'd0)
		else $error("word on error result");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(m_tdata[38:32]) <= 32'(CAPACITY))
		else $error("length beyond capacity");

endmodule

bind indexed_list_shift_store_top ilss_checker u_ilss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/testbench.sv =====
// Testbench for indexed_list_shift_store_top: list commands checked against a behavioral list.
module testbench;
	import ilss_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
	localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
	localparam logic [POS_W-1:0] POS_TOP = 6'd63;
	localparam int RANDOM_ITEMS = 400;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [LEN_W-1:0]  len;
		logic [STAT_W-1:0] stat;
	} list_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;  // command[2:0], position[8:3], word_in[40:9], zero pad
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;  // word_out[31:0], length[38:32], status[40:39], zero pad

	logic [WORD_W-1:0] list_words [CAPACITY];
	int list_len;
	list_result_t pending_results[$];

	int failures;
	int requests_sent;
	int results_checked;
	int range_hits;
	int full_hits;
	int input_stall_cycles;
	int burst_left;
	bit steady_send;
	int hold_len;
	int hold_token;

	indexed_list_shift_store_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic list_result_t apply_list_op(logic [CMD_W-1:0] op, logic [POS_W-1:0] idx,
			logic [WORD_W-1:0] word);
		list_result_t r;
		bit hit;
		int i;
		r = '0;
		hit = int'(idx) < list_len;
		case (op)
		CMD_APPEND: begin
			if (list_len >= CAPACITY) begin
				r.stat = ST_FULL;
			end else begin
				list_words[list_len] = word;
				list_len++;
			end
		end
		CMD_SET: begin
			if (!hit) r.stat = ST_RANGE;
			else list_words[idx] = word;
		end
		CMD_INSERT: begin
			if (!hit) begin
				r.stat = ST_RANGE;
			end else if (list_len >= CAPACITY) begin
				r.stat = ST_FULL;
			end else begin
				for (i = list_len; i > int'(idx); i--) list_words[i] = list_words[i-1];
				list_words[idx] = word;
				list_len++;
			end
		end
		CMD_GET: begin
			if (!hit) r.stat = ST_RANGE;
			else r.word = list_words[idx];
		end
		CMD_DELETE: begin
			if (!hit) begin
				r.stat = ST_RANGE;
			end else begin
				for (i = int'(idx); i + 1 < list_len; i++) list_words[i] = list_words[i+1];
				list_len--;
			end
		end
		default: ;
		endcase
		r.len = list_len[LEN_W-1:0];
		if (r.stat == ST_RANGE) range_hits++;
		if (r.stat == ST_FULL) full_hits++;
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 15))
		0: return WORD_MAX;
		1: return WORD_MIN;
		2: return '0;
		3: return '1;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		if (list_len > 0 && $urandom_range(0, 99) < 85)
			return POS_W'($urandom_range(0, list_len - 1));
		if (list_len < CAPACITY && $urandom_range(0, 1) == 0)
			return POS_W'($urandom_range(list_len, CAPACITY - 1));
		return POS_W'($urandom_range(0, CAPACITY - 1));
	endfunction

	task automatic send_request(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] idx,
			input logic [WORD_W-1:0] word);
		int gap;
		if (!steady_send && burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0) burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, word, idx, op};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(apply_list_op(op, idx, word));
		requests_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic note_failure(input string what, input logic [WORD_W-1:0] exp_v,
			input logic [WORD_W-1:0] got_v);
		failures++;
		if (failures <= 10)
			$display("mismatch %s: expected %h got %h at %0t", what, exp_v, got_v, $realtime);
	endtask

	// receiver: random ready in changing modes, plus long hold-offs on request
	initial begin : drive_ready
		int mode;
		int mode_left;
		int hold_left;
		int hold_seen;
		int pct;
		m_tready = 1'b0;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = hold_len;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 64);
			end
			mode_left--;
			case (mode)
			0: pct = 100;
			1: pct = 75;
			2: pct = 50;
			default: pct = 20;
			endcase
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	always @(posedge clk) begin : check_results
		list_result_t got;
		list_result_t exp_r;
		if (arst_n && s_tvalid && !s_tready) input_stall_cycles++;
		if (arst_n && m_tvalid && m_tready) begin
			got.word = m_tdata[31:0];
			got.len = m_tdata[38:32];
			got.stat = m_tdata[40:39];
			results_checked++;
			if (pending_results.size() == 0) begin
				note_failure("unexpected result", '0, m_tdata[31:0]);
			end else begin
				exp_r = pending_results.pop_front();
				if (got.word !== exp_r.word) note_failure("word_out", exp_r.word, got.word);
				if (got.len !== exp_r.len) note_failure("length", exp_r.len, got.len);
				if (got.stat !== exp_r.stat) note_failure("status", exp_r.stat, got.stat);
			end
		end
	end

	task automatic test_empty_store();
		send_request(CMD_GET, '0, '0);
		send_request(CMD_SET, POS_TOP, WORD_MAX);
		send_request(CMD_INSERT, '0, '1);
		send_request(CMD_DELETE, POS_TOP, '0);
		send_request(CMD_SPARE_LO, POS_TOP, '1);
		send_request(CMD_SPARE_HI, POS_TOP, WORD_MIN);
		wait_drained();
	endtask

	task automatic test_edit_ops();
		send_request(CMD_APPEND, '0, WORD_MAX);
		send_request(CMD_APPEND, POS_TOP, WORD_MIN);
		send_request(CMD_APPEND, '0, '0);
		send_request(CMD_APPEND, '0, '1);
		send_request(CMD_INSERT, '0, 32'h1234_5678);
		send_request(CMD_INSERT, 6'(list_len - 1), 32'hcafe_f00d);
		send_request(CMD_INSERT, 6'(list_len), 32'h0bad_0bad);
		send_request(CMD_SET, 6'd2, 32'h5a5a_a5a5);
		send_request(CMD_SET, 6'(list_len), '1);
		for (int i = 0; i < 6; i++) send_request(CMD_GET, 6'(i), $urandom);
		send_request(CMD_GET, 6'(list_len), '0);
		send_request(CMD_DELETE, '0, '0);
		send_request(CMD_DELETE, 6'(list_len - 1), '0);
		send_request(CMD_DELETE, 6'(list_len), '0);
		send_request(CMD_GET, '0, '0);
		wait_drained();
	endtask

	task automatic test_capacity();
		while (list_len < CAPACITY) send_request(CMD_APPEND, pick_position(), pick_word());
		send_request(CMD_APPEND, '0, WORD_MAX);
		send_request(CMD_INSERT, '0, WORD_MIN);
		send_request(CMD_INSERT, POS_TOP, '1);
		send_request(CMD_GET, POS_TOP, '0);
		send_request(CMD_SET, POS_TOP, WORD_MIN);
		send_request(CMD_DELETE, POS_TOP, '0);
		send_request(CMD_INSERT, 6'd62, WORD_MAX);
		send_request(CMD_GET, POS_TOP, '0);
		while (list_len > 0)
			send_request(CMD_DELETE, POS_W'($urandom_range(0, list_len - 1)), '0);
		send_request(CMD_DELETE, '0, '0);
		wait_drained();
	endtask

	// long receiver hold-off while the sender keeps offering back to back
	task automatic test_backpressure();
		hold_len = 80;
		hold_token++;
		steady_send = 1'b1;
		for (int i = 0; i < 40; i++) begin
			if (i % 2 == 0) send_request(CMD_APPEND, '0, pick_word());
			else send_request(CMD_GET, pick_position(), '0);
		end
		steady_send = 1'b0;
		wait_drained();
	endtask

	task automatic test_random_commands();
		int known;
		int roll;
		bit grow;
		logic [CMD_W-1:0] op;
		known = 0;
		grow = 1'b1;
		while (known < RANDOM_ITEMS) begin
			if (list_len == CAPACITY && $urandom_range(0, 3) == 0) grow = 1'b0;
			if (list_len == 0) grow = 1'b1;
			if ($urandom_range(0, 99) == 0) grow = !grow;
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				op = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
			end else if (grow) begin
				if (roll < 38) op = CMD_APPEND;
				else if (roll < 63) op = CMD_INSERT;
				else if (roll < 75) op = CMD_SET;
				else if (roll < 90) op = CMD_GET;
				else op = CMD_DELETE;
			end else begin
				if (roll < 48) op = CMD_DELETE;
				else if (roll < 68) op = CMD_GET;
				else if (roll < 83) op = CMD_SET;
				else if (roll < 93) op = CMD_APPEND;
				else op = CMD_INSERT;
			end
			send_request(op, pick_position(), pick_word());
			if (op <= CMD_DELETE) known++;
			if (known % 150 == 149) wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		failures = 0;
		requests_sent = 0;
		results_checked = 0;
		range_hits = 0;
		full_hits = 0;
		input_stall_cycles = 0;
		burst_left = 0;
		steady_send = 1'b0;
		hold_len = 0;
		hold_token = 0;
		list_len = 0;
		foreach (list_words[i]) list_words[i] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_store();
		test_edit_ops();
		test_capacity();
		test_backpressure();
		test_random_commands();

		repeat (10) @(posedge clk);
		$display("%0d requests, %0d results checked; %0d out-of-range and %0d full responses",
			requests_sent, results_checked, range_hits, full_hits);
		$display("input held off for %0d cycles by output stalls", input_stall_cycles);
		if (failures == 0 && pending_results.size() == 0) begin
			$display("indexed_list_shift_store_top regression: pass");
		end else begin
			$display("indexed_list_shift_store_top regression: fail");
		end
		$finish;
	end

	initial begin
		#1600000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("indexed_list_shift_store_top regression: fail");
		$finish;
	end

endmodule
